@@ hdl/dvft_pkg.sv @@
// ----------------------------------------------------------------------------
// Distinct value frequency table: shared definitions
// Operation and result codes, and the command and status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package dvft_pkg;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_DUMP   = 1'b1;

  localparam logic [1:0] KIND_ACK   = 2'd0;
  localparam logic [1:0] KIND_ENTRY = 2'd1;
  localparam logic [1:0] KIND_EMPTY = 2'd2;

  typedef struct packed {
    logic load_sample;
    logic ptr_inc;
    logic ack_hit;
    logic ack_new;
    logic ack_ovf;
    logic dump_entry;
    logic dump_empty;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic match;
    logic at_last;
    logic used_zero;
    logic full;
    logic slot_free;
  } status_t;

endpackage

@@ hdl/dvft_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, with the read data registered.
// ----------------------------------------------------------------------------
module dvft_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/dvft_ctrl.sv @@
// ----------------------------------------------------------------------------
// Distinct value frequency table: controller
// Sequences the table scan for a sample and the entry walk for a dump.
// ----------------------------------------------------------------------------
module dvft_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              op_i,
  output logic              in_stall_o,
  input  dvft_pkg::status_t status_i,
  output dvft_pkg::cmd_t    cmd_o
);

  import dvft_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_CMP   = 3'd2;
  localparam logic [2:0] S_HIT   = 3'd3;
  localparam logic [2:0] S_MISS  = 3'd4;
  localparam logic [2:0] D_READ  = 3'd5;
  localparam logic [2:0] D_EMIT  = 3'd6;
  localparam logic [2:0] D_EMPTY = 3'd7;

  logic [2:0] state_q, state_d;
  logic       accept;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.load_sample = 1'b1;
          if (op_i == OP_DUMP) begin
            state_d = status_i.used_zero ? D_EMPTY : D_READ;
          end else begin
            state_d = status_i.used_zero ? S_MISS : S_READ;
          end
        end
      end
      S_READ: begin
        state_d = S_CMP;
      end
      S_CMP: begin
        if (status_i.match) begin
          state_d = S_HIT;
        end else if (status_i.at_last) begin
          state_d = S_MISS;
        end else begin
          cmd_o.ptr_inc = 1'b1;
          state_d       = S_READ;
        end
      end
      S_HIT: begin
        if (status_i.slot_free) begin
          cmd_o.ack_hit = 1'b1;
          state_d       = S_IDLE;
        end
      end
      S_MISS: begin
        if (status_i.slot_free) begin
          if (status_i.full) begin
            cmd_o.ack_ovf = 1'b1;
          end else begin
            cmd_o.ack_new = 1'b1;
          end
          state_d = S_IDLE;
        end
      end
      D_READ: begin
        state_d = D_EMIT;
      end
      D_EMIT: begin
        if (status_i.slot_free) begin
          cmd_o.dump_entry = 1'b1;
          if (status_i.at_last) begin
            cmd_o.clear = 1'b1;
            state_d     = S_IDLE;
          end else begin
            cmd_o.ptr_inc = 1'b1;
            state_d       = D_READ;
          end
        end
      end
      D_EMPTY: begin
        if (status_i.slot_free) begin
          cmd_o.dump_empty = 1'b1;
          state_d          = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.ack_hit, cmd_o.ack_new, cmd_o.ack_ovf,
              cmd_o.dump_entry, cmd_o.dump_empty}))
    else $error("More than one result loaded in one cycle.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.ack_hit || cmd_o.ack_new || cmd_o.ack_ovf || cmd_o.dump_entry ||
     cmd_o.dump_empty) |-> status_i.slot_free)
    else $error("Result loaded while the output register is occupied.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.clear |-> (cmd_o.dump_entry && status_i.at_last))
    else $error("Table cleared before its last entry was emitted.");

endmodule

@@ hdl/dvft_datapath.sv @@
// ----------------------------------------------------------------------------
// Distinct value frequency table: datapath
// Holds the key and count memories, the fill count, the scan pointer and the
// output register.
// ----------------------------------------------------------------------------
module dvft_datapath #(
  parameter int TABLE_DEPTH = 64,
  parameter int VALUE_WIDTH = 32,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  dvft_pkg::cmd_t                         cmd_i,
  output dvft_pkg::status_t                      status_o,
  input  logic signed [VALUE_WIDTH-1:0]          value_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic [1:0]                             kind_o,
  output logic [$clog2(TABLE_DEPTH)-1:0]         entry_index_o,
  output logic signed [VALUE_WIDTH-1:0]          entry_value_o,
  output logic [COUNT_WIDTH-1:0]                 entry_count_o,
  output logic                                   is_new_o,
  output logic                                   overflow_o,
  output logic [$clog2(TABLE_DEPTH+1)-1:0]       entries_used_o,
  output logic                                   last_o
);

  import dvft_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int UW = $clog2(TABLE_DEPTH + 1);

  logic [UW-1:0]          used_q, used_d;
  logic [AW-1:0]          ptr_q, ptr_d;
  logic [VALUE_WIDTH-1:0] sample_q;
  logic [VALUE_WIDTH-1:0] key_rdata;
  logic [COUNT_WIDTH-1:0] cnt_rdata;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic                   key_we, cnt_we;
  logic [AW-1:0]          waddr;
  logic [COUNT_WIDTH-1:0] cnt_wdata;
  logic                   load;

  logic                   out_valid_q, out_valid_d;
  logic [1:0]             kind_q, kind_d;
  logic [AW-1:0]          index_q, index_d;
  logic [VALUE_WIDTH-1:0] value_q, value_d;
  logic [COUNT_WIDTH-1:0] count_q, count_d;
  logic                   new_q, new_d;
  logic                   ovf_q, ovf_d;
  logic [UW-1:0]          uout_q, uout_d;
  logic                   last_q, last_d;

  assign cnt_inc = (&cnt_rdata) ? cnt_rdata : cnt_rdata + COUNT_WIDTH'(1);

  assign key_we    = cmd_i.ack_new;
  assign cnt_we    = cmd_i.ack_new || cmd_i.ack_hit;
  assign waddr     = cmd_i.ack_new ? used_q[AW-1:0] : ptr_q;
  assign cnt_wdata = cmd_i.ack_new ? COUNT_WIDTH'(1) : cnt_inc;

  dvft_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (TABLE_DEPTH)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (waddr),
    .wdata_i (sample_q),
    .raddr_i (ptr_q),
    .rdata_o (key_rdata)
  );

  dvft_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (TABLE_DEPTH)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (waddr),
    .wdata_i (cnt_wdata),
    .raddr_i (ptr_q),
    .rdata_o (cnt_rdata)
  );

  assign status_o.match     = (key_rdata == sample_q);
  assign status_o.at_last   = ((UW'(ptr_q) + UW'(1)) == used_q);
  assign status_o.used_zero = (used_q == '0);
  assign status_o.full      = (used_q == UW'(TABLE_DEPTH));
  assign status_o.slot_free = !out_valid_q || !out_stall_i;

  assign load = cmd_i.ack_hit || cmd_i.ack_new || cmd_i.ack_ovf ||
                cmd_i.dump_entry || cmd_i.dump_empty;

  always_comb begin
    used_d = used_q;
    ptr_d  = ptr_q;
    if (cmd_i.load_sample) begin
      ptr_d = '0;
    end else if (cmd_i.ptr_inc) begin
      ptr_d = ptr_q + AW'(1);
    end
    if (cmd_i.clear) begin
      used_d = '0;
    end else if (cmd_i.ack_new) begin
      used_d = used_q + UW'(1);
    end
  end

  always_comb begin
    kind_d  = kind_q;
    index_d = index_q;
    value_d = value_q;
    count_d = count_q;
    new_d   = new_q;
    ovf_d   = ovf_q;
    uout_d  = uout_q;
    last_d  = last_q;
    if (cmd_i.ack_hit) begin
      kind_d  = KIND_ACK;
      index_d = ptr_q;
      value_d = sample_q;
      count_d = cnt_inc;
      new_d   = 1'b0;
      ovf_d   = 1'b0;
      uout_d  = used_q;
      last_d  = 1'b1;
    end else if (cmd_i.ack_new) begin
      kind_d  = KIND_ACK;
      index_d = used_q[AW-1:0];
      value_d = sample_q;
      count_d = COUNT_WIDTH'(1);
      new_d   = 1'b1;
      ovf_d   = 1'b0;
      uout_d  = used_q + UW'(1);
      last_d  = 1'b1;
    end else if (cmd_i.ack_ovf) begin
      kind_d  = KIND_ACK;
      index_d = '0;
      value_d = sample_q;
      count_d = '0;
      new_d   = 1'b0;
      ovf_d   = 1'b1;
      uout_d  = used_q;
      last_d  = 1'b1;
    end else if (cmd_i.dump_entry) begin
      kind_d  = KIND_ENTRY;
      index_d = ptr_q;
      value_d = key_rdata;
      count_d = cnt_rdata;
      new_d   = 1'b0;
      ovf_d   = 1'b0;
      uout_d  = used_q;
      last_d  = status_o.at_last;
    end else if (cmd_i.dump_empty) begin
      kind_d  = KIND_EMPTY;
      index_d = '0;
      value_d = '0;
      count_d = '0;
      new_d   = 1'b0;
      ovf_d   = 1'b0;
      uout_d  = '0;
      last_d  = 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= '0;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      used_q      <= used_d;
      ptr_q       <= ptr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_sample) begin
      sample_q <= value_i;
    end
    kind_q  <= kind_d;
    index_q <= index_d;
    value_q <= value_d;
    count_q <= count_d;
    new_q   <= new_d;
    ovf_q   <= ovf_d;
    uout_q  <= uout_d;
    last_q  <= last_d;
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = kind_q;
  assign entry_index_o  = index_q;
  assign entry_value_o  = value_q;
  assign entry_count_o  = count_q;
  assign is_new_o       = new_q;
  assign overflow_o     = ovf_q;
  assign entries_used_o = uout_q;
  assign last_o         = last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= UW'(TABLE_DEPTH))
    else $error("Fill count exceeds the table depth.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.ack_new |-> !status_o.full)
    else $error("Entry appended to a full table.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.ack_new |=> (used_q == $past(used_q) + UW'(1)))
    else $error("Fill count did not advance after an append.");

endmodule

@@ hdl/distinct_value_frequency_table.sv @@
// ----------------------------------------------------------------------------
// Distinct value frequency table
// Counts the distinct values of a sample stream, in order of first appearance.
//
// The input channel takes an op and a value; an op of zero counts the value,
// an op of one dumps the table and then empties it. Each sample gives one
// acknowledgement transaction; a dump gives one transaction per entry, or a
// single empty marker, with last set on the final one.
// The key and count memories are searched one entry at a time through their
// single read port, each entry passing through a read state and a compare
// state. A sample that matches an entry is acknowledged from the hit state;
// one that misses goes to the miss state, straight from idle when the table
// is empty, and the next input is taken once the controller is back in idle.
// A dump walks the entries in turn through a read state and an emit state.
// The output register holds a result while out_stall_i is high; the block
// meanwhile accepts the next input and waits only when it has a new result
// ready. Reset empties the table and the output register; the memories need
// no clearing pass because only filled entries are ever read.
// ----------------------------------------------------------------------------
module distinct_value_frequency_table #(
  parameter int TABLE_DEPTH = 64,
  parameter int VALUE_WIDTH = 32,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             op_i,
  input  logic signed [VALUE_WIDTH-1:0]    value_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [1:0]                       kind_o,
  output logic [$clog2(TABLE_DEPTH)-1:0]   entry_index_o,
  output logic signed [VALUE_WIDTH-1:0]    entry_value_o,
  output logic [COUNT_WIDTH-1:0]           entry_count_o,
  output logic                             is_new_o,
  output logic                             overflow_o,
  output logic [$clog2(TABLE_DEPTH+1)-1:0] entries_used_o,
  output logic                             last_o
);

  import dvft_pkg::*;

  cmd_t    cmd;
  status_t status;

  dvft_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .op_i       (op_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  dvft_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .value_i        (value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .entry_index_o  (entry_index_o),
    .entry_value_o  (entry_value_o),
    .entry_count_o  (entry_count_o),
    .is_new_o       (is_new_o),
    .overflow_o     (overflow_o),
    .entries_used_o (entries_used_o),
    .last_o         (last_o)
  );

endmodule
